// ===== sv/nbwc_pkg.sv =====
package nbwc_pkg;

    // Fixed field and state widths
    localparam int IDX_W   = 12;
    localparam int WCNT_W  = 16;
    localparam int CNT_W   = 32;
    localparam int TOT_W   = 44;
    localparam int SCORE_W = 48;
    localparam int NORM_W  = 44;
    localparam int EXP_W   = 6;
    localparam int MANT_W  = 32;

    // Opcodes
    localparam logic OP_TRAIN    = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // Input word
    typedef struct packed {
        logic              opcode;
        logic [IDX_W-1:0]  word_index;
        logic [WCNT_W-1:0] word_count;
        logic              class_label;
        logic              last_of_record;
    } t_in;

    // Result word
    typedef struct packed {
        logic                      predicted_spam;
        logic signed [SCORE_W-1:0] spam_score;
        logic signed [SCORE_W-1:0] ham_score;
    } t_out;

    // Sequencer states
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_TRAIN = 8'b0000_1000,
        S_NORM  = 8'b0001_0000,
        S_SQR   = 8'b0010_0000,
        S_ACC   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    // Log operand select
    typedef enum logic [1:0] {
        SEL_SPAM_CNT = 2'd0,
        SEL_SPAM_TOT = 2'd1,
        SEL_HAM_CNT  = 2'd2,
        SEL_HAM_TOT  = 2'd3
    } t_sel;

endpackage

// ===== sv/nbwc_ram.sv =====
module nbwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/naive_bayes_word_classifier.sv =====
// Two-class multinomial naive Bayes word classifier. A training word adds its count to the
// per-word and per-class counts of its class (both saturate); a classify word whose count is
// nonzero and whose word was seen in both classes adds log2(count/total) of each class to that
// class's score, and the last word of a record returns one result (spam when spam score >=
// not-spam score, with both scores) and clears the scores. After reset the block sweeps both
// count memories to zero and takes no word until done. A training word is read and then
// written back; a classify word that adds nothing is read and then finished. A scoring classify
// word runs four log2 evaluations one after another on a single unit, each a 6-step leading-one
// search followed by one 32x32 squaring per fraction bit, and then adds to the scores. The
// result sits in an output register, so a stalled result only holds the block when the next
// record's last word is ready to report.
module naive_bayes_word_classifier
    import nbwc_pkg::*;
#(
    parameter int VOCAB_SIZE    = 4096,
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int AW     = $clog2(VOCAB_SIZE);
    localparam int IDXX_W = 17;
    localparam int LW     = EXP_W + LOG_FRAC_BITS;
    localparam int DW     = LW + 1;
    localparam int SUM_W  = SCORE_W + 1;
    localparam int STEP_W = $clog2(LOG_FRAC_BITS > 6 ? LOG_FRAC_BITS : 6);

    localparam logic signed [SUM_W-1:0] SCORE_MAX = SUM_W'((64'd1 << (SCORE_W - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] SCORE_MIN = -SCORE_MAX - SUM_W'(1);

    t_state r_state, n_state;
    t_sel   r_sel, n_sel;
    logic [AW-1:0]   r_clr, n_clr;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_op, n_op;
    logic            r_valid_idx, n_valid_idx;
    logic [WCNT_W-1:0] r_wcnt, n_wcnt;
    logic            r_label, n_label;
    logic            r_last, n_last;
    logic [CNT_W-1:0] r_cnt_s, n_cnt_s, r_cnt_h, n_cnt_h;
    logic [TOT_W-1:0] r_tot_s, n_tot_s, r_tot_h, n_tot_h;
    logic signed [SCORE_W-1:0] r_score_s, n_score_s, r_score_h, n_score_h;
    logic signed [DW-1:0] r_diff_s, n_diff_s, r_diff_h, n_diff_h;
    logic [NORM_W-1:0] r_lx, n_lx;
    logic [EXP_W-1:0]  r_lsh, n_lsh, r_le, n_le;
    logic [STEP_W-1:0] r_step, n_step;
    logic [MANT_W-1:0] r_m, n_m;
    logic [LOG_FRAC_BITS-1:0] r_frac, n_frac;
    logic            r_lzero, n_lzero;
    logic            r_out_valid, n_out_valid;
    t_out            r_out, n_out;

    logic [IDXX_W-1:0] idx_x;
    logic [AW-1:0]     ram_raddr, ram_waddr;
    logic              we_s, we_h;
    logic [CNT_W-1:0]  wdata, rdata_s, rdata_h;
    logic [CNT_W:0]    cnt_sum;
    logic [TOT_W:0]    tot_sum;
    logic [CNT_W-1:0]  cnt_cur, cnt_new;
    logic [TOT_W-1:0]  tot_cur, tot_new;
    logic [NORM_W-1:0] operand;
    logic [EXP_W-1:0]  norm_k;
    logic              top_zero;
    logic [2*MANT_W-1:0] prod;
    logic [MANT_W:0]   sq;
    logic [LW-1:0]     lval;
    logic signed [SUM_W-1:0] sum_s, sum_h;

    // Count memories
    nbwc_ram #(.WIDTH(CNT_W), .DEPTH(VOCAB_SIZE)) u_spam_ram (
        .i_clk   (i_clk),
        .i_we    (we_s),
        .i_waddr (ram_waddr),
        .i_wdata (wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata_s)
    );

    nbwc_ram #(.WIDTH(CNT_W), .DEPTH(VOCAB_SIZE)) u_ham_ram (
        .i_clk   (i_clk),
        .i_we    (we_h),
        .i_waddr (ram_waddr),
        .i_wdata (wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata_h)
    );

    assign idx_x     = IDXX_W'(i_in_data.word_index);
    assign ram_raddr = (r_state == S_IDLE) ? idx_x[AW-1:0] : r_addr;
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign we_s      = (r_state == S_CLEAR) || ((r_state == S_TRAIN) && r_label);
    assign we_h      = (r_state == S_CLEAR) || ((r_state == S_TRAIN) && !r_label);
    assign wdata     = (r_state == S_CLEAR) ? '0 : cnt_new;

    // Saturating training update
    assign cnt_cur = r_label ? r_cnt_s : r_cnt_h;
    assign tot_cur = r_label ? r_tot_s : r_tot_h;
    assign cnt_sum = (CNT_W+1)'(cnt_cur) + (CNT_W+1)'(r_wcnt);
    assign tot_sum = (TOT_W+1)'(tot_cur) + (TOT_W+1)'(r_wcnt);
    assign cnt_new = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
    assign tot_new = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];

    // Leading-one search step size
    always_comb begin
        case (r_step)
            STEP_W'(0): norm_k = EXP_W'(32);
            STEP_W'(1): norm_k = EXP_W'(16);
            STEP_W'(2): norm_k = EXP_W'(8);
            STEP_W'(3): norm_k = EXP_W'(4);
            STEP_W'(4): norm_k = EXP_W'(2);
            default:    norm_k = EXP_W'(1);
        endcase
    end
    assign top_zero = (r_lx >> (EXP_W'(NORM_W) - norm_k)) == '0;

    // Shared squaring unit
    assign prod = (2*MANT_W)'(r_m) * (2*MANT_W)'(r_m);
    assign sq   = prod[2*MANT_W-1:MANT_W-1];
    assign lval = r_lzero ? '0 : {r_le, r_frac[LOG_FRAC_BITS-2:0], sq[MANT_W]};

    // Saturating score update
    assign sum_s = SUM_W'(r_score_s) + SUM_W'(r_diff_s);
    assign sum_h = SUM_W'(r_score_h) + SUM_W'(r_diff_h);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_op        = r_op;
        n_valid_idx = r_valid_idx;
        n_wcnt      = r_wcnt;
        n_label     = r_label;
        n_last      = r_last;
        n_cnt_s     = r_cnt_s;
        n_cnt_h     = r_cnt_h;
        n_tot_s     = r_tot_s;
        n_tot_h     = r_tot_h;
        n_score_s   = r_score_s;
        n_score_h   = r_score_h;
        n_diff_s    = r_diff_s;
        n_diff_h    = r_diff_h;
        n_lx        = r_lx;
        n_lsh       = r_lsh;
        n_le        = r_le;
        n_step      = r_step;
        n_m         = r_m;
        n_frac      = r_frac;
        n_lzero     = r_lzero;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        operand     = '0;

        // Drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(VOCAB_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op        = i_in_data.opcode;
                    n_addr      = idx_x[AW-1:0];
                    n_valid_idx = idx_x < IDXX_W'(VOCAB_SIZE);
                    n_wcnt      = i_in_data.word_count;
                    n_label     = i_in_data.class_label;
                    n_last      = i_in_data.last_of_record;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                n_cnt_s = rdata_s;
                n_cnt_h = rdata_h;
                if (r_op == OP_TRAIN) begin
                    n_state = r_valid_idx ? S_TRAIN : S_IDLE;
                end else if (r_valid_idx && r_wcnt != '0 && rdata_s != '0
                             && rdata_h != '0) begin
                    n_sel   = SEL_SPAM_CNT;
                    n_lx    = NORM_W'(rdata_s);
                    n_lzero = 1'b0;
                    n_lsh   = '0;
                    n_step  = '0;
                    n_state = S_NORM;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_TRAIN: begin
                if (r_label) begin
                    n_tot_s = tot_new;
                end else begin
                    n_tot_h = tot_new;
                end
                n_state = S_IDLE;
            end
            S_NORM: begin
                if (top_zero) begin
                    n_lx  = r_lx << norm_k;
                    n_lsh = r_lsh + norm_k;
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(5)) begin
                    n_m     = n_lx[NORM_W-1 -: MANT_W];
                    n_le    = EXP_W'(NORM_W - 1) - n_lsh;
                    n_frac  = '0;
                    n_step  = '0;
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                n_m    = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
                n_frac = {r_frac[LOG_FRAC_BITS-2:0], sq[MANT_W]};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(LOG_FRAC_BITS - 1)) begin
                    // Fold this log into the class difference, then load the next operand
                    case (r_sel)
                        SEL_SPAM_CNT: n_diff_s = DW'(lval);
                        SEL_SPAM_TOT: n_diff_s = r_diff_s - DW'(lval);
                        SEL_HAM_CNT:  n_diff_h = DW'(lval);
                        default:      n_diff_h = r_diff_h - DW'(lval);
                    endcase
                    case (r_sel)
                        SEL_SPAM_CNT: operand = NORM_W'(r_tot_s);
                        SEL_SPAM_TOT: operand = NORM_W'(r_cnt_h);
                        default:      operand = NORM_W'(r_tot_h);
                    endcase
                    n_lx    = operand;
                    n_lzero = operand == '0;
                    n_lsh   = '0;
                    n_step  = '0;
                    n_sel   = t_sel'(r_sel + 2'd1);
                    n_state = (r_sel == SEL_HAM_TOT) ? S_ACC : S_NORM;
                end
            end
            S_ACC: begin
                n_score_s = (sum_s > SCORE_MAX) ? SCORE_W'(SCORE_MAX) :
                            (sum_s < SCORE_MIN) ? SCORE_W'(SCORE_MIN) : SCORE_W'(sum_s);
                n_score_h = (sum_h > SCORE_MAX) ? SCORE_W'(SCORE_MAX) :
                            (sum_h < SCORE_MIN) ? SCORE_W'(SCORE_MIN) : SCORE_W'(sum_h);
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    // Report the record and clear the scores
                    n_out.predicted_spam = r_score_s >= r_score_h;
                    n_out.spam_score     = r_score_s;
                    n_out.ham_score      = r_score_h;
                    n_out_valid          = 1'b1;
                    n_score_s            = '0;
                    n_score_h            = '0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_tot_s     <= '0;
            r_tot_h     <= '0;
            r_score_s   <= '0;
            r_score_h   <= '0;
            r_out_valid <= 1'b0;
            r_sel       <= SEL_SPAM_CNT;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_tot_s     <= n_tot_s;
            r_tot_h     <= n_tot_h;
            r_score_s   <= n_score_s;
            r_score_h   <= n_score_h;
            r_out_valid <= n_out_valid;
            r_sel       <= n_sel;
            r_step      <= n_step;
        end
        r_addr      <= n_addr;
        r_op        <= n_op;
        r_valid_idx <= n_valid_idx;
        r_wcnt      <= n_wcnt;
        r_label     <= n_label;
        r_last      <= n_last;
        r_cnt_s     <= n_cnt_s;
        r_cnt_h     <= n_cnt_h;
        r_diff_s    <= n_diff_s;
        r_diff_h    <= n_diff_h;
        r_lx        <= n_lx;
        r_lsh       <= n_lsh;
        r_le        <= n_le;
        r_m         <= n_m;
        r_frac      <= n_frac;
        r_lzero     <= n_lzero;
        r_out       <= n_out;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_clear_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("word accepted during clearing pass");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_READ))
        else $error("accepted word did not start a read");

    a_mant_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQR && !r_lzero) |-> r_m[MANT_W-1])
        else $error("mantissa left [1,2) during squaring");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN && r_last))
        else $error("result raised outside record end");

endmodule

// ===== bench/naive_bayes_word_classifier_check.sv =====
module naive_bayes_word_classifier_check
    import nbwc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int VOCAB = 4096;
    localparam int FRAC  = 16;
    localparam logic [CNT_W-1:0] CNT_SAT = '1;
    localparam logic [TOT_W-1:0] TOT_SAT = '1;
    localparam logic signed [SCORE_W-1:0] SCORE_TOP = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_BOT = {1'b1, {(SCORE_W-1){1'b0}}};

    logic [CNT_W-1:0] spam_cnt [VOCAB];
    logic [CNT_W-1:0] ham_cnt  [VOCAB];
    logic [TOT_W-1:0] spam_tot;
    logic [TOT_W-1:0] ham_tot;
    logic signed [SCORE_W-1:0] spam_acc;
    logic signed [SCORE_W-1:0] ham_acc;
    t_out verdicts [$];

    // Fixed-point log2 by repeated squaring
    function automatic longint fixed_log2(input logic [63:0] x);
        int e;
        logic [63:0] m;
        logic [127:0] sq;
        longint r;
        if (x == 0) return 0;
        e = 0;
        for (int b = 0; b < 64; b++) if (x[b]) e = b;
        m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
        r = e;
        for (int i = 0; i < FRAC; i++) begin
            sq = m * m;
            m  = sq >> 31;
            r  = r << 1;
            if (m >= 64'h1_0000_0000) begin
                r = r | 1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic signed [SCORE_W-1:0] score_add(
        input logic signed [SCORE_W-1:0] a, input longint b);
        longint s;
        s = longint'(a) + b;
        if (s > longint'(SCORE_TOP)) return SCORE_TOP;
        if (s < longint'(SCORE_BOT)) return SCORE_BOT;
        return s[SCORE_W-1:0];
    endfunction

    // Apply one accepted word to the predicted state
    task automatic classify_word(input t_in w);
        logic [63:0] nc;
        logic [63:0] nt;
        longint ts;
        longint th;
        t_out v;
        if (w.opcode == OP_TRAIN) begin
            if (w.class_label) begin
                nc = spam_cnt[w.word_index] + w.word_count;
                nt = spam_tot + w.word_count;
                spam_cnt[w.word_index] = (nc > CNT_SAT) ? CNT_SAT : nc[CNT_W-1:0];
                spam_tot = (nt > TOT_SAT) ? TOT_SAT : nt[TOT_W-1:0];
            end else begin
                nc = ham_cnt[w.word_index] + w.word_count;
                nt = ham_tot + w.word_count;
                ham_cnt[w.word_index] = (nc > CNT_SAT) ? CNT_SAT : nc[CNT_W-1:0];
                ham_tot = (nt > TOT_SAT) ? TOT_SAT : nt[TOT_W-1:0];
            end
            return;
        end
        if (w.word_count != 0 && spam_cnt[w.word_index] != 0 && ham_cnt[w.word_index] != 0)
            begin
            ts = fixed_log2(spam_cnt[w.word_index]) - fixed_log2(spam_tot);
            th = fixed_log2(ham_cnt[w.word_index]) - fixed_log2(ham_tot);
            spam_acc = score_add(spam_acc, ts);
            ham_acc  = score_add(ham_acc, th);
        end
        if (w.last_of_record) begin
            v.predicted_spam = (spam_acc >= ham_acc);
            v.spam_score     = spam_acc;
            v.ham_score      = ham_acc;
            verdicts.insert(verdicts.size(), v);
            spam_acc = '0;
            ham_acc  = '0;
        end
    endtask

    assign o_pending = verdicts.size();

    // Track accepted words and compare results
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (spam_cnt[k]) begin
                spam_cnt[k] = '0;
                ham_cnt[k]  = '0;
            end
            spam_tot = '0;
            ham_tot  = '0;
            spam_acc = '0;
            ham_acc  = '0;
            verdicts.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdicts.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_out_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = verdicts.pop_front();
                    if (want.predicted_spam !== i_out_data.predicted_spam) begin
                        $display("%0t: predicted_spam expected %0d actual %0d", $time,
                                 want.predicted_spam, i_out_data.predicted_spam);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (want.spam_score !== i_out_data.spam_score) begin
                        $display("%0t: spam_score expected %0d actual %0d", $time,
                                 want.spam_score, i_out_data.spam_score);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (want.ham_score !== i_out_data.ham_score) begin
                        $display("%0t: ham_score expected %0d actual %0d", $time,
                                 want.ham_score, i_out_data.ham_score);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) classify_word(i_in_data);
        end
    end

endmodule

// ===== bench/naive_bayes_word_classifier_test.sv =====
module naive_bayes_word_classifier_test;
    import nbwc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_word;
    logic out_valid;
    logic out_stall;
    t_out out_word;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   quiet;
    bit   hold_long;
    logic [IDX_W-1:0] vocab [8];

    naive_bayes_word_classifier i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_word)
    );

    naive_bayes_word_classifier_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // End the run at the cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("naive_bayes_word_classifier_test: FAIL");
            $finish;
        end
    end

    // Stall the result side in bursts, with one long hold
    initial begin
        bit long_done;
        long_done = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long && !long_done) begin
                out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                out_stall <= 1'b0;
                long_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one word and hold it until accepted
    task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [WCNT_W-1:0] cnt, input logic lbl, input logic lst);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{opcode: op, word_index: idx, word_count: cnt, class_label: lbl,
                      last_of_record: lst};
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    task automatic random_word(input bit small_vocab);
        logic [IDX_W-1:0] idx;
        logic [WCNT_W-1:0] cnt;
        idx = small_vocab ? vocab[$urandom_range(0, 7)] : IDX_W'($urandom);
        cnt = ($urandom_range(0, 7) == 0) ? WCNT_W'($urandom_range(0, 1)) : WCNT_W'($urandom);
        if ($urandom_range(0, 2) == 0)
            send_word(OP_TRAIN, idx, cnt, 1'($urandom), 1'($urandom));
        else
            send_word(OP_CLASSIFY, idx, cnt, 1'($urandom), $urandom_range(0, 3) == 0);
    endtask

    initial begin
        quiet     = 1'b0;
        hold_long = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        i_rst_n   = 1'b0;
        foreach (vocab[k]) vocab[k] = IDX_W'($urandom);
        vocab[0] = '0;
        vocab[1] = '1;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty record, unseen word, one-sided word, extremes, ties
        send_word(OP_CLASSIFY, 12'd5, 16'd3, 1'b0, 1'b1);
        send_word(OP_TRAIN, 12'd0, 16'hFFFF, 1'b1, 1'b1);
        send_word(OP_CLASSIFY, 12'd0, 16'd1, 1'b0, 1'b1);
        send_word(OP_TRAIN, 12'd0, 16'd1, 1'b0, 1'b0);
        send_word(OP_TRAIN, 12'hFFF, 16'd1, 1'b1, 1'b0);
        send_word(OP_TRAIN, 12'hFFF, 16'hFFFF, 1'b0, 1'b0);
        send_word(OP_TRAIN, 12'd7, 16'd0, 1'b1, 1'b0);
        send_word(OP_CLASSIFY, 12'd0, 16'hFFFF, 1'b1, 1'b0);
        send_word(OP_CLASSIFY, 12'hFFF, 16'd0, 1'b0, 1'b0);
        send_word(OP_CLASSIFY, 12'hFFF, 16'd1, 1'b1, 1'b1);
        send_word(OP_TRAIN, 12'hAAA, 16'h5555, 1'b1, 1'b0);
        send_word(OP_TRAIN, 12'hAAA, 16'h5555, 1'b0, 1'b0);
        send_word(OP_CLASSIFY, 12'hAAA, 16'hAAAA, 1'b0, 1'b1);
        send_word(OP_CLASSIFY, 12'h555, 16'h1, 1'b0, 1'b1);

        // Long hold on results while words keep coming
        hold_long = 1'b1;
        repeat (40) random_word(1'b1);
        // Random: mostly a small vocabulary so words get seen in both classes
        repeat (800) random_word($urandom_range(0, 4) != 0);
        quiet = 1'b1;
        repeat (100) random_word(1'b1);
        send_word(OP_CLASSIFY, vocab[2], 16'd1, 1'b0, 1'b1);
        in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0)
            $display("naive_bayes_word_classifier_test: PASS");
        else
            $display("naive_bayes_word_classifier_test: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/nbwc_pkg.sv
sv/nbwc_ram.sv
sv/naive_bayes_word_classifier.sv
bench/naive_bayes_word_classifier_check.sv
bench/naive_bayes_word_classifier_test.sv
